>>> rtl/core/sctbl_pkg.sv
// Shared types, constants and default table contents for the calibration table interpolator.
package sctbl_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned DEF_N          = 6;

  localparam logic [37:0] FREQ_SCALE  = 38'd256000000000;
  localparam logic [15:0] NO_PTS_DAC  = 16'd10;
  localparam logic signed [22:0] EPS_MV = 23'sd50;

  // iteration counts of the shared units
  localparam logic [5:0] FDIV_STEPS = 6'd38;
  localparam logic [5:0] VDIV_STEPS = 6'd22;
  localparam logic [5:0] DDIV_STEPS = 6'd17;
  localparam logic [4:0] MUL_STEPS  = 5'd21;

  typedef enum logic [2:0] {
    OP_CAPTURE = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_P2V     = 3'd2,
    OP_V2D     = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_INC,
    PTR_LAST
  } ptr_e;

  typedef enum logic [2:0] {
    RK_FAIL,
    RK_OK,
    RK_NOPTS,
    RK_READ,
    RK_CUR,
    RK_PREV,
    RK_QUOT
  } res_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_CDIV,
    ST_CAPW,
    ST_RMW,
    ST_FIN,
    ST_PDIV,
    ST_LO,
    ST_HI,
    ST_SPAN,
    ST_MUL1,
    ST_MUL2,
    ST_QDIV
  } state_e;

  typedef struct packed {
    logic load;
    ptr_e ptr_op;
    logic scan;
    logic prev_ld;
    logic fdiv;
    logic qdiv;
    logic mul_start;
    logic mul_second;
    logic cap_wr;
    logic rm_wr;
    logic res_en;
    res_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic cap_bad;
    logic idx_ok;
    logic few_pts;
    logic per_zero;
    logic full;
    logic hit_now;
    logic scan_end;
    logic key_le;
    logic key_ge;
    logic flat;
    logic mul_busy;
    logic div_busy;
  } st_t;

  function automatic logic [20:0] def_volts(int unsigned k);
    logic [20:0] r;
    case (k)
      0: r = 21'd0;
      1: r = 21'd20000;
      2: r = 21'd100000;
      3: r = 21'd500000;
      4: r = 21'd1000000;
      5: r = 21'd1500000;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  function automatic logic [39:0] def_freq(int unsigned k);
    logic [39:0] r;
    case (k)
      0: r = 40'd0;
      1: r = 40'd64000;
      2: r = 40'd296960;
      3: r = 40'd1589760;
      4: r = 40'd3187200;
      5: r = 40'd4776192;
      default: r = 40'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/sorted_calibration_table_interpolator_top.sv
// Sorted calibration table interpolator top level: sequencer plus datapath.
// Reads and rejects finish at decode; capture scans the table for a match or insert point, then
//   divides and writes (a full table with no match is rejected after the scan); period-to-volts
//   and volts-to-dac search the spans in turn, so they run longer for a higher span index.
// Throughput: one command at a time, busy until the result is registered; the 38-step freq
//   divide, 21-step multiply and 22/17-step quotient divides are what a command waits on.
// Reset: asynchronous, active low, loads six default points; one strobed beat per result.
module sorted_calibration_table_interpolator_top #(
  parameter int unsigned MAX_POINTS = sctbl_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic signed [21:0] volts_mv_i,
  input  logic [31:0]        period_i,
  input  logic [15:0]        cap_code_i,
  input  logic [3:0]         point_index_i,
  input  logic               monitor_valid_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [20:0]        volts_out_mv_o,
  output logic [15:0]        dac_out_o,
  output logic [20:0]        entry_volts_mv_o,
  output logic [39:0]        entry_freq_o,
  output logic [15:0]        entry_dac_o,
  output logic [4:0]         point_count_o
);
  import sctbl_pkg::*;

  // command and status bundles between sequencer and datapath
  cmd_t cmd;
  st_t  st;

  sctbl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // table, scan pointer, multiplier and divider all live here
  sctbl_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .opcode_i         (opcode_i),
    .volts_mv_i       (volts_mv_i),
    .period_i         (period_i),
    .cap_code_i       (cap_code_i),
    .point_index_i    (point_index_i),
    .monitor_valid_i  (monitor_valid_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .volts_out_mv_o   (volts_out_mv_o),
    .dac_out_o        (dac_out_o),
    .entry_volts_mv_o (entry_volts_mv_o),
    .entry_freq_o     (entry_freq_o),
    .entry_dac_o      (entry_dac_o),
    .point_count_o    (point_count_o)
  );

  // a command beat is only taken while idle
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

endmodule

>>> rtl/core/sctbl_ctrl.sv
// Sequencer for the calibration table: decodes a command and steps the datapath.
module sctbl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sctbl_pkg::st_t  st_i,
  output sctbl_pkg::cmd_t cmd_o
);
  import sctbl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_DISP;
      ST_DISP: begin
        unique case (st_i.op)
          OP_CAPTURE: state_d = st_i.cap_bad ? ST_IDLE : ST_SCAN;
          OP_REMOVE:  state_d = st_i.idx_ok ? ST_RMW : ST_IDLE;
          OP_P2V:     state_d = (st_i.per_zero || st_i.few_pts) ? ST_IDLE : ST_PDIV;
          OP_V2D:     state_d = st_i.few_pts ? ST_IDLE : ST_LO;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (st_i.hit_now) state_d = ST_CDIV;
        else if (st_i.scan_end) state_d = st_i.full ? ST_IDLE : ST_CDIV;
      end
      ST_CDIV: if (!st_i.div_busy) state_d = ST_CAPW;
      ST_CAPW: state_d = ST_FIN;
      ST_RMW:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      ST_PDIV: if (!st_i.div_busy) state_d = ST_LO;
      ST_LO:   state_d = st_i.key_le ? ST_IDLE : ST_HI;
      ST_HI:   state_d = st_i.key_ge ? ST_IDLE : ST_SPAN;
      ST_SPAN: begin
        if (st_i.key_le) state_d = st_i.flat ? ST_IDLE : ST_MUL1;
      end
      ST_MUL1: begin
        if (!st_i.mul_busy) state_d = (st_i.op == OP_V2D) ? ST_MUL2 : ST_QDIV;
      end
      ST_MUL2: if (!st_i.mul_busy) state_d = ST_QDIV;
      ST_QDIV: if (!st_i.div_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.ptr_op   = PTR_HOLD;
    cmd_o.res_kind = RK_FAIL;
    unique case (state_q)
      ST_IDLE: cmd_o.load = start;
      ST_DISP: begin
        unique case (st_i.op)
          OP_CAPTURE: begin
            if (st_i.cap_bad) cmd_o.res_en = 1'b1;
            else cmd_o.ptr_op = PTR_ZERO;
          end
          OP_REMOVE: cmd_o.res_en = !st_i.idx_ok;
          OP_P2V: begin
            if (st_i.per_zero || st_i.few_pts) begin
              cmd_o.res_en   = 1'b1;
              cmd_o.res_kind = RK_NOPTS;
            end else begin
              cmd_o.fdiv = 1'b1;
            end
          end
          OP_V2D: begin
            if (st_i.few_pts) begin
              cmd_o.res_en   = 1'b1;
              cmd_o.res_kind = RK_NOPTS;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
            end
          end
          OP_READ: begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_kind = st_i.idx_ok ? RK_READ : RK_FAIL;
          end
          default: cmd_o.res_en = 1'b1;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.ptr_op = PTR_INC;
        if (st_i.hit_now || (st_i.scan_end && !st_i.full)) cmd_o.fdiv = 1'b1;
        else if (st_i.scan_end) cmd_o.res_en = 1'b1;
      end
      ST_CDIV: ;
      ST_CAPW: cmd_o.cap_wr = 1'b1;
      ST_RMW:  cmd_o.rm_wr = 1'b1;
      ST_FIN: begin
        cmd_o.res_en   = 1'b1;
        cmd_o.res_kind = RK_OK;
      end
      ST_PDIV: if (!st_i.div_busy) cmd_o.ptr_op = PTR_ZERO;
      ST_LO: begin
        cmd_o.prev_ld = 1'b1;
        if (st_i.key_le) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RK_CUR;
        end else begin
          cmd_o.ptr_op = PTR_LAST;
        end
      end
      ST_HI: begin
        if (st_i.key_ge) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RK_CUR;
        end else begin
          cmd_o.ptr_op = PTR_ONE;
        end
      end
      ST_SPAN: begin
        if (st_i.key_le) begin
          if (st_i.flat) begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_kind = RK_PREV;
          end else begin
            cmd_o.mul_start = 1'b1;
          end
        end else begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.ptr_op  = PTR_INC;
        end
      end
      ST_MUL1: begin
        if (!st_i.mul_busy) begin
          if (st_i.op == OP_V2D) begin
            cmd_o.mul_start  = 1'b1;
            cmd_o.mul_second = 1'b1;
          end else begin
            cmd_o.qdiv = 1'b1;
          end
        end
      end
      ST_MUL2: cmd_o.qdiv = !st_i.mul_busy;
      ST_QDIV: begin
        if (!st_i.div_busy) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RK_QUOT;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmd_o.res_en) else $error("result issued while idle");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fdiv || cmd_o.qdiv) |-> !st_i.div_busy) else $error("divider restarted while busy");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |-> !st_i.mul_busy) else $error("multiplier restarted while busy");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_en |=> (state_q == ST_IDLE)) else $error("sequencer not idle after result");

endmodule

>>> rtl/core/sctbl_dp.sv
// Datapath: point table, scan pointer, shift-add multiplier, restoring divider, result regs.
module sctbl_dp #(
  parameter int unsigned MAX_POINTS = sctbl_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sctbl_pkg::cmd_t    cmd_i,
  output sctbl_pkg::st_t     st_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [21:0] volts_mv_i,
  input  logic [31:0]        period_i,
  input  logic [15:0]        cap_code_i,
  input  logic [3:0]         point_index_i,
  input  logic               monitor_valid_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [20:0]        volts_out_mv_o,
  output logic [15:0]        dac_out_o,
  output logic [20:0]        entry_volts_mv_o,
  output logic [39:0]        entry_freq_o,
  output logic [15:0]        entry_dac_o,
  output logic [4:0]         point_count_o
);
  import sctbl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = $clog2(MAX_POINTS);

  // latched command
  logic [2:0]         op_q;
  logic signed [21:0] v_q;
  logic [31:0]        per_q;
  logic [15:0]        dac_q;
  logic               mon_q;
  logic [3:0]         idx_q;

  // table
  logic [20:0] tv_q [MAX_POINTS];
  logic [39:0] tf_q [MAX_POINTS];
  logic [15:0] td_q [MAX_POINTS];
  logic [CW-1:0] cnt_q, ptr_q, pos_q;
  logic hit_q, posf_q;
  logic [20:0] prev_v_q;
  logic [39:0] prev_f_q;
  logic [15:0] prev_d_q;

  // multiplier
  logic [4:0]  mcnt_q;
  logic [60:0] mcand_q;
  logic [20:0] mplier_q;
  logic [61:0] acc_q;

  // divider
  logic [5:0]  dcnt_q;
  logic [40:0] rem_q;
  logic [63:0] dvd_q;
  logic [40:0] den_q;
  logic [39:0] quo_q;

  // results
  logic        done_q, ok_q;
  logic [20:0] vout_q, ev_q;
  logic [15:0] dout_q, ed_q;
  logic [39:0] ef_q;
  logic [4:0]  pc_q;

  logic [20:0] ent_v;
  logic [39:0] ent_f;
  logic [15:0] ent_d;
  logic signed [21:0] ent_vs;
  logic signed [22:0] vdiff;
  logic match, vol_lt, is_p2v;
  logic [CW+3:0] idx_w, idx_in_w, cnt_w;
  logic [CW+4:0] cnt_pc_w;
  logic [37:0] fnum;
  logic [39:0] fden;
  logic [20:0] vden;
  logic [62:0] qnum_p, qnum_d;
  logic [41:0] r2;
  logic        r_ge;

  assign ent_v  = tv_q[ptr_q[PW-1:0]];
  assign ent_f  = tf_q[ptr_q[PW-1:0]];
  assign ent_d  = td_q[ptr_q[PW-1:0]];
  assign ent_vs = $signed({1'b0, ent_v});
  assign vdiff  = $signed({2'b00, ent_v}) - $signed({v_q[21], v_q});
  assign match  = (vdiff <= EPS_MV) && (vdiff >= -EPS_MV);
  assign vol_lt = ent_vs < v_q;
  assign is_p2v = (op_q == OP_P2V);

  assign idx_w    = {{CW{1'b0}}, idx_q};
  assign idx_in_w = {{CW{1'b0}}, point_index_i};
  assign cnt_w    = {4'b0000, cnt_q};
  assign cnt_pc_w = {5'b00000, cnt_q};

  assign fnum   = FREQ_SCALE + {7'b0000000, per_q[31:1]};
  assign fden   = ent_f - prev_f_q;
  assign vden   = ent_v - prev_v_q;
  assign qnum_p = {1'b0, acc_q} + {24'd0, fden[39:1]};
  assign qnum_d = {acc_q, 1'b0} + {42'd0, vden};

  assign r2   = {rem_q, dvd_q[63]};
  assign r_ge = r2 >= {1'b0, den_q};

  always_comb begin
    st_o          = '0;
    st_o.op       = op_q;
    st_o.cap_bad  = v_q[21] || !mon_q || (per_q == 32'd0);
    st_o.idx_ok   = idx_w < cnt_w;
    st_o.few_pts  = cnt_q < CW'(2);
    st_o.per_zero = (per_q == 32'd0);
    st_o.full     = cnt_q >= CW'(MAX_POINTS);
    st_o.scan_end = ptr_q >= cnt_q;
    st_o.hit_now  = !st_o.scan_end && match;
    st_o.key_le   = is_p2v ? (quo_q <= ent_f) : (v_q <= ent_vs);
    st_o.key_ge   = is_p2v ? (quo_q >= ent_f) : (v_q >= ent_vs);
    st_o.flat     = is_p2v ? (ent_f <= prev_f_q) : (ent_v <= prev_v_q);
    st_o.mul_busy = (mcnt_q != 5'd0);
    st_o.div_busy = (dcnt_q != 6'd0);
  end

  // command latch, pointer, scan bookkeeping, span registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      pos_q  <= '0;
      hit_q  <= 1'b0;
      posf_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ptr_q  <= idx_in_w[CW-1:0];
        hit_q  <= 1'b0;
        posf_q <= 1'b0;
      end else begin
        case (cmd_i.ptr_op)
          PTR_ZERO: ptr_q <= '0;
          PTR_ONE:  ptr_q <= CW'(1);
          PTR_INC:  ptr_q <= ptr_q + CW'(1);
          PTR_LAST: ptr_q <= cnt_q - CW'(1);
          default:  ptr_q <= ptr_q;
        endcase
      end
      if (cmd_i.scan) begin
        if (!st_o.scan_end) begin
          if (match) begin
            hit_q <= 1'b1;
            pos_q <= ptr_q;
          end else if (!posf_q && !vol_lt) begin
            posf_q <= 1'b1;
            pos_q  <= ptr_q;
          end
        end else if (!posf_q) begin
          pos_q <= cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      v_q   <= volts_mv_i;
      per_q <= period_i;
      dac_q <= cap_code_i;
      mon_q <= monitor_valid_i;
      idx_q <= point_index_i;
    end
    if (cmd_i.prev_ld) begin
      prev_v_q <= ent_v;
      prev_f_q <= ent_f;
      prev_d_q <= ent_d;
    end
  end

  // table storage, loaded with the default points at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        tv_q[k] <= def_volts(k);
        tf_q[k] <= def_freq(k);
        td_q[k] <= (k < DEF_N) ? NO_PTS_DAC : 16'd0;
      end
      cnt_q <= (MAX_POINTS < DEF_N) ? CW'(MAX_POINTS) : CW'(DEF_N);
    end else if (cmd_i.cap_wr) begin
      if (hit_q) begin
        tf_q[pos_q[PW-1:0]] <= quo_q;
        td_q[pos_q[PW-1:0]] <= dac_q;
      end else begin
        for (int k = 1; k < MAX_POINTS; k++) begin
          if ((CW'(k) > pos_q) && (CW'(k) <= cnt_q)) begin
            tv_q[k] <= tv_q[k-1];
            tf_q[k] <= tf_q[k-1];
            td_q[k] <= td_q[k-1];
          end
        end
        tv_q[pos_q[PW-1:0]] <= v_q[20:0];
        tf_q[pos_q[PW-1:0]] <= quo_q;
        td_q[pos_q[PW-1:0]] <= dac_q;
        cnt_q <= cnt_q + CW'(1);
      end
    end else if (cmd_i.rm_wr) begin
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
        if (CW'(k) >= ptr_q) begin
          tv_q[k] <= tv_q[k+1];
          tf_q[k] <= tf_q[k+1];
          td_q[k] <= td_q[k+1];
        end
      end
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= 5'd0;
    end else if (cmd_i.mul_start) begin
      mcnt_q <= MUL_STEPS;
    end else if (mcnt_q != 5'd0) begin
      mcnt_q <= mcnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      if (!cmd_i.mul_second) acc_q <= '0;
      if (is_p2v) begin
        mcand_q  <= {21'd0, quo_q - prev_f_q};
        mplier_q <= ent_v - prev_v_q;
      end else if (!cmd_i.mul_second) begin
        mcand_q  <= {45'd0, prev_d_q};
        mplier_q <= ent_v - v_q[20:0];
      end else begin
        mcand_q  <= {45'd0, ent_d};
        mplier_q <= v_q[20:0] - prev_v_q;
      end
    end else if (mcnt_q != 5'd0) begin
      if (mplier_q[0]) acc_q <= acc_q + {1'b0, mcand_q};
      mcand_q  <= {mcand_q[59:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[20:1]};
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= 6'd0;
    end else if (cmd_i.fdiv) begin
      dcnt_q <= FDIV_STEPS;
    end else if (cmd_i.qdiv) begin
      dcnt_q <= is_p2v ? VDIV_STEPS : DDIV_STEPS;
    end else if (dcnt_q != 6'd0) begin
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fdiv) begin
      rem_q <= '0;
      dvd_q <= {fnum, 26'd0};
      den_q <= {9'd0, per_q};
      quo_q <= '0;
    end else if (cmd_i.qdiv) begin
      quo_q <= '0;
      if (is_p2v) begin
        rem_q <= qnum_p[62:22];
        dvd_q <= {qnum_p[21:0], 42'd0};
        den_q <= {1'b0, fden};
      end else begin
        rem_q <= qnum_d[57:17];
        dvd_q <= {qnum_d[16:0], 47'd0};
        den_q <= {19'd0, vden, 1'b0};
      end
    end else if (dcnt_q != 6'd0) begin
      rem_q <= r_ge ? 41'(r2 - {1'b0, den_q}) : r2[40:0];
      dvd_q <= {dvd_q[62:0], 1'b0};
      quo_q <= {quo_q[38:0], r_ge};
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      ok_q   <= (cmd_i.res_kind != RK_FAIL);
      vout_q <= '0;
      dout_q <= '0;
      ev_q   <= '0;
      ef_q   <= '0;
      ed_q   <= '0;
      pc_q   <= cnt_pc_w[4:0];
      case (cmd_i.res_kind)
        RK_NOPTS: if (!is_p2v) dout_q <= NO_PTS_DAC;
        RK_READ: begin
          ev_q <= ent_v;
          ef_q <= ent_f;
          ed_q <= ent_d;
        end
        RK_CUR: begin
          if (is_p2v) vout_q <= ent_v;
          else dout_q <= ent_d;
        end
        RK_PREV: begin
          if (is_p2v) vout_q <= prev_v_q;
          else dout_q <= prev_d_q;
        end
        RK_QUOT: begin
          if (is_p2v) vout_q <= prev_v_q + quo_q[20:0];
          else dout_q <= quo_q[15:0];
        end
        default: ;
      endcase
    end
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign volts_out_mv_o   = vout_q;
  assign dac_out_o        = dout_q;
  assign entry_volts_mv_o = ev_q;
  assign entry_freq_o     = ef_q;
  assign entry_dac_o      = ed_q;
  assign point_count_o    = pc_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS)) else $error("point count beyond table depth");

  a_rm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_wr |=> (cnt_q == CW'($past(cnt_q) - CW'(1)))) else $error("remove lost count");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.res_en)) else $error("strobe without result request");

endmodule
